>>> sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is low
`define TWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define TWS_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/tws_pkg.sv
// types and constants of the prefix tree word store
`default_nettype none

package tws_pkg;

    localparam int unsigned NODE_COUNT    = 1024;
    localparam int unsigned ALPHABET_SIZE = 26;
    localparam int unsigned TABLE_DEPTH   = NODE_COUNT * ALPHABET_SIZE;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned LETTER_W = 5;
    localparam int unsigned NODE_W   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int unsigned FREE_W   = $clog2(NODE_COUNT + 1);
    localparam int unsigned ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int unsigned ALPHA_W  = $clog2(ALPHABET_SIZE + 1);
    localparam int unsigned CMP_W    = (ALPHA_W > LETTER_W) ? ALPHA_W : LETTER_W;

    localparam int unsigned Q_DEPTH  = 2;
    localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;

    // one classified letter item on its way to the tree walker
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [LETTER_W-1:0] letter;
        logic                walk;
        logic                first;
        logic                last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

endpackage

`default_nettype wire

>>> sv/tws_if.sv
// handshake channels for letter items and word results
`default_nettype none

interface tws_in_if;
    logic                           valid;
    logic                           ready;
    logic [tws_pkg::OP_W-1:0]       opcode;
    logic [tws_pkg::LETTER_W-1:0]   letter;
    logic                           has_letter;
    logic                           last_letter;

    modport source (output valid, opcode, letter, has_letter, last_letter, input ready);
    modport sink   (input valid, opcode, letter, has_letter, last_letter, output ready);
endinterface

interface tws_out_if;
    logic valid;
    logic ready;
    logic found;
    logic status;

    modport source (output valid, found, status, input ready);
    modport sink   (input valid, found, status, output ready);
endinterface

`default_nettype wire

>>> sv/tws_front.sv
// front end: tracks word boundaries and classifies each letter item
`default_nettype none

module tws_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    tws_in_if.sink          i_in,
    input  wire logic       i_clearing,
    input  wire logic       i_q_ready,
    output tws_pkg::t_push  o_push
);

    logic                       r_inside;
    logic [tws_pkg::OP_W-1:0]   r_word_op;
    logic                       n_inside;
    logic [tws_pkg::OP_W-1:0]   n_word_op;
    logic                       first;
    logic [tws_pkg::OP_W-1:0]   op_e;
    logic                       in_range;
    logic                       take;

    assign first    = !r_inside;
    assign op_e     = first ? i_in.opcode : r_word_op;
    assign in_range = tws_pkg::CMP_W'(i_in.letter) < tws_pkg::CMP_W'(tws_pkg::ALPHABET_SIZE);

    assign i_in.ready = !i_clearing && i_q_ready;
    assign take       = i_in.valid && i_in.ready;

    always_comb begin
        o_push.valid      = take;
        o_push.cmd.op     = op_e;
        o_push.cmd.letter = i_in.letter;
        // opcode 3 walks nothing
        o_push.cmd.walk   = i_in.has_letter && in_range &&
                            (op_e == tws_pkg::OP_INSERT || op_e == tws_pkg::OP_SEARCH ||
                             op_e == tws_pkg::OP_PREFIX);
        o_push.cmd.first  = first;
        o_push.cmd.last   = i_in.last_letter;
    end

    always_comb begin
        n_inside  = r_inside;
        n_word_op = r_word_op;
        if (take) begin
            n_inside = !i_in.last_letter;
            if (first) begin
                n_word_op = i_in.opcode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside  <= 1'b0;
            r_word_op <= tws_pkg::OP_INSERT;
        end else begin
            r_inside  <= n_inside;
            r_word_op <= n_word_op;
        end
    end

endmodule

`default_nettype wire

>>> sv/tws_queue.sv
// short command queue between front end and tree walker
`default_nettype none

module tws_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tws_pkg::t_push i_push,
    output logic                o_ready,
    input  wire logic           i_pop,
    output logic                o_head_valid,
    output tws_pkg::t_cmd       o_head
);

    tws_pkg::t_cmd                  r_ent [tws_pkg::Q_DEPTH];
    logic [tws_pkg::Q_PTR_W-1:0]    r_wp;
    logic [tws_pkg::Q_PTR_W-1:0]    r_rp;
    logic [tws_pkg::Q_CNT_W-1:0]    r_cnt;
    logic [tws_pkg::Q_PTR_W-1:0]    n_wp;
    logic [tws_pkg::Q_PTR_W-1:0]    n_rp;
    logic [tws_pkg::Q_CNT_W-1:0]    n_cnt;
    logic                           push;
    logic                           pop;

    assign o_ready      = r_cnt != tws_pkg::Q_CNT_W'(tws_pkg::Q_DEPTH);
    assign o_head_valid = r_cnt != '0;
    assign o_head       = r_ent[r_rp];
    assign push         = i_push.valid && o_ready;
    assign pop          = i_pop && o_head_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == tws_pkg::Q_PTR_W'(tws_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == tws_pkg::Q_PTR_W'(tws_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> sv/tws_back.sv
// tree walker: child table, word marks, node allocation and result register
`default_nettype none

module tws_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire tws_pkg::t_cmd  i_head,
    output logic                o_pop,
    output logic                o_clearing,
    tws_out_if.source           o_out
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [tws_pkg::NODE_W-1:0] child_mem [tws_pkg::TABLE_DEPTH];
    logic                       mark_mem  [tws_pkg::NODE_COUNT];

    logic [1:0]                 r_state,  n_state;
    logic [tws_pkg::ADDR_W-1:0] r_clr,    n_clr;
    logic [tws_pkg::FREE_W-1:0] r_free,   n_free;
    logic [tws_pkg::NODE_W-1:0] r_cur,    n_cur;
    logic                       r_fail,   n_fail;
    logic [tws_pkg::OP_W-1:0]   r_op,     n_op;
    logic                       r_last,   n_last;
    logic [tws_pkg::ADDR_W-1:0] r_addr,   n_addr;
    logic                       r_out_valid, n_out_valid;
    logic                       r_found,  n_found;
    logic                       r_status, n_status;
    logic [tws_pkg::NODE_W-1:0] r_rd_child;
    logic                       r_rd_mark;

    logic                       c_we, c_re;
    logic [tws_pkg::ADDR_W-1:0] c_wa, c_ra;
    logic [tws_pkg::NODE_W-1:0] c_wd;
    logic                       m_we, m_re, m_wd;
    logic [tws_pkg::NODE_W-1:0] m_wa, m_ra;

    logic [tws_pkg::NODE_W-1:0] cur_e;
    logic                       fail_e;
    logic [tws_pkg::ADDR_W-1:0] addr_e;
    logic [tws_pkg::NODE_W-1:0] nxt;
    logic                       grant;
    logic                       done;

    // a new word restarts at the root
    assign cur_e  = i_head.first ? '0 : r_cur;
    assign fail_e = i_head.first ? 1'b0 : r_fail;
    assign addr_e = tws_pkg::ADDR_W'(cur_e) * tws_pkg::ADDR_W'(tws_pkg::ALPHABET_SIZE)
                  + tws_pkg::ADDR_W'(i_head.letter);
    assign grant  = (r_op == tws_pkg::OP_INSERT) &&
                    (r_free < tws_pkg::FREE_W'(tws_pkg::NODE_COUNT));

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_free   = r_free;
        n_cur    = r_cur;
        n_fail   = r_fail;
        n_op     = r_op;
        n_last   = r_last;
        n_addr   = r_addr;
        n_found  = r_found;
        n_status = r_status;
        c_we     = 1'b0;
        c_wa     = r_addr;
        c_wd     = '0;
        c_re     = 1'b0;
        c_ra     = addr_e;
        m_we     = 1'b0;
        m_wa     = r_cur;
        m_wd     = 1'b0;
        m_re     = 1'b0;
        m_ra     = r_cur;
        nxt      = r_cur;
        o_pop    = 1'b0;
        done     = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                c_we  = 1'b1;
                c_wa  = r_clr;
                if (r_clr < tws_pkg::ADDR_W'(tws_pkg::NODE_COUNT)) begin
                    m_we = 1'b1;
                    m_wa = r_clr[tws_pkg::NODE_W-1:0];
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == tws_pkg::ADDR_W'(tws_pkg::TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop  = 1'b1;
                    n_op   = i_head.op;
                    n_last = i_head.last;
                    n_cur  = cur_e;
                    n_fail = fail_e;
                    if (i_head.walk && !fail_e) begin
                        c_re    = 1'b1;
                        c_ra    = addr_e;
                        n_addr  = addr_e;
                        n_state = S_LOOK;
                    end else if (i_head.last) begin
                        m_re    = 1'b1;
                        m_ra    = cur_e;
                        n_state = S_DONE;
                    end
                end
            end
            S_LOOK: begin
                if (r_rd_child != '0) begin
                    nxt = r_rd_child;
                end else if (grant) begin
                    nxt    = r_free[tws_pkg::NODE_W-1:0];
                    c_we   = 1'b1;
                    c_wa   = r_addr;
                    c_wd   = r_free[tws_pkg::NODE_W-1:0];
                    n_free = r_free + 1'b1;
                end else begin
                    n_fail = 1'b1;
                end
                n_cur = nxt;
                if (r_last) begin
                    m_re    = 1'b1;
                    m_ra    = nxt;
                    n_state = S_DONE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                // wait for the result register to be free
                if (!r_out_valid || o_out.ready) begin
                    done     = 1'b1;
                    n_found  = 1'b0;
                    n_status = 1'b0;
                    unique case (r_op)
                        tws_pkg::OP_INSERT: begin
                            if (r_fail) begin
                                n_status = 1'b1;
                            end else begin
                                n_found = 1'b1;
                                m_we    = 1'b1;
                                m_wa    = r_cur;
                                m_wd    = 1'b1;
                            end
                        end
                        tws_pkg::OP_SEARCH: n_found = !r_fail && r_rd_mark;
                        tws_pkg::OP_PREFIX: n_found = !r_fail;
                        default:            n_found = 1'b0;
                    endcase
                    n_cur   = '0;
                    n_fail  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase

        n_out_valid = done || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            child_mem[c_wa] <= c_wd;
        end
        if (c_re) begin
            r_rd_child <= child_mem[c_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mark_mem[m_wa] <= m_wd;
        end
        if (m_re) begin
            r_rd_mark <= mark_mem[m_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free      <= tws_pkg::FREE_W'(1);
            r_cur       <= '0;
            r_fail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free      <= n_free;
            r_cur       <= n_cur;
            r_fail      <= n_fail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_last   <= n_last;
        r_addr   <= n_addr;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign o_clearing   = (r_state == S_CLEAR);
    assign o_out.valid  = r_out_valid;
    assign o_out.found  = r_found;
    assign o_out.status = r_status;

endmodule

`default_nettype wire

>>> sv/trie_word_store.sv
// prefix tree word store: insert, whole-word search and prefix test
//
// Items arrive on i_in one letter per transfer with an opcode; the opcode of
// a word's first item applies to the whole word and last_letter closes it.
// Each closed word gives one transfer on o_out with found and status.
// A front end takes one item per cycle, while the queue has room and no
// clear pass runs, into a two-entry queue; for each letter the walker
// behind it reads the child table, then allocates or follows, in states
// S_IDLE and S_LOOK; an item without a letter is handled in S_IDLE alone.
// The word's last item also reads the end mark and passes through S_DONE,
// which writes the mark on insert and registers the result. The walker
// takes no new item while it finishes a letter.
// After reset the walker clears the child table (node count times alphabet
// size entries) and the end marks, one entry per cycle, while i_in.ready
// stays low. When o_out is stalled the result waits in its register; the
// walker holds the next result and the queue then fills and drops i_in.ready.
`default_nettype none

`include "assert_macros.svh"

module trie_word_store (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tws_in_if.sink      i_in,
    tws_out_if.source   o_out
);

    tws_pkg::t_push     q_push;
    logic               q_ready;
    logic               q_pop;
    logic               q_head_valid;
    tws_pkg::t_cmd      q_head;
    logic               clearing;

    tws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_clearing (clearing),
        .i_q_ready  (q_ready),
        .o_push     (q_push)
    );

    tws_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .o_ready      (q_ready),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    tws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_clearing   (clearing),
        .o_out        (o_out)
    );

    `TWS_ASSERT(a_no_take_in_clear, i_clk, i_rst_n, clearing |-> !(i_in.valid && i_in.ready), "item taken during clear pass")
    `TWS_ASSERT_NORST(a_clear_after_reset, i_clk, !i_rst_n |=> clearing, "clear pass not started by reset")
    `TWS_ASSERT(a_pop_needs_entry, i_clk, i_rst_n, q_pop |-> (q_head_valid && !clearing), "walker popped an empty queue")

endmodule

`default_nettype wire
